[src/grid_rectangle_first_fit_defines.svh]
`ifndef GRID_RECTANGLE_FIRST_FIT_DEFINES_SVH
`define GRID_RECTANGLE_FIRST_FIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GFIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GFIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/gfit_pkg.sv]
package gfit_pkg;

  localparam int MAX_COLS = 16;
  localparam int MAX_ROWS = 16;

  // fixed field widths of the item formats
  localparam int F_IDX_W = 4;
  localparam int F_CNT_W = 5;
  localparam int F_OP_W  = 2;
  localparam int F_ST_W  = 2;
  localparam int CFG_W   = 5;

  localparam int COL_IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_CW = $clog2(MAX_COLS + 1);
  localparam int ROW_CW = $clog2(MAX_ROWS + 1);
  localparam int HGT_W  = ROW_CW;

  localparam int MAX_A  = (F_CNT_W > COL_CW) ? F_CNT_W : COL_CW;
  localparam int MAX_B  = (MAX_A > ROW_CW) ? MAX_A : ROW_CW;
  localparam int SUM_W  = ((MAX_B > CFG_W) ? MAX_B : CFG_W) + 1;

  localparam int IN_W   = 24;
  localparam int OUT_W  = 16;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic [F_OP_W-1:0] {
    OP_MARK  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FIND  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [F_ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_OOB     = 2'd1,
    ST_NOSPACE = 2'd2
  } status_t;

  typedef enum logic {
    REG_GRID_COLUMNS = 1'b0,
    REG_GRID_ROWS    = 1'b1
  } reg_idx_t;

  typedef logic [MAX_COLS-1:0] row_word_t;
  typedef logic [MAX_COLS-1:0][HGT_W-1:0] hgt_vec_t;

  // operands the sequencer hands to the row unit
  typedef struct packed {
    logic              set_bits;
    logic [F_IDX_W-1:0] col;
    logic [F_CNT_W-1:0] cols;
    logic [F_CNT_W-1:0] rows;
    logic [COL_CW-1:0]  grid_cols;
  } row_op_t;

  typedef struct packed {
    logic              hit;
    logic [COL_IW-1:0] col;
  } fit_res_t;

endpackage

[src/gfit_occ_bank.sv]
module gfit_occ_bank
  import gfit_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ROW_IW-1:0] rd_idx,
  output row_word_t         rd_data,
  input  logic              wr_en,
  input  logic [ROW_IW-1:0] wr_idx,
  input  row_word_t         wr_data
);

  row_word_t occ_r [MAX_ROWS];

  assign rd_data = occ_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ROWS; i++) begin
        occ_r[i] <= '0;
      end
    end else if (wr_en) begin
      occ_r[wr_idx] <= wr_data;
    end
  end

endmodule

[src/gfit_row_unit.sv]
module gfit_row_unit
  import gfit_pkg::*;
(
  input  row_op_t   op,
  input  row_word_t row_word,
  input  hgt_vec_t  hgt,
  output row_word_t row_new,
  output hgt_vec_t  hgt_nxt,
  output fit_res_t  fit
);

  row_word_t                 mask;
  row_word_t                 ok;
  logic [2*MAX_COLS-1:0]     ok_ext;
  row_word_t                 fit_vec;
  logic                      win;

  // rectangle mask over columns col .. col+cols-1
  always_comb begin
    for (int x = 0; x < MAX_COLS; x++) begin
      mask[x] = (SUM_W'(x) >= SUM_W'(op.col)) &&
                (SUM_W'(x) < SUM_W'(op.col) + SUM_W'(op.cols));
    end
  end

  assign row_new = op.set_bits ? (row_word | mask) : (row_word & ~mask);

  // free-run height per column, ending at the current row
  always_comb begin
    for (int x = 0; x < MAX_COLS; x++) begin
      if (row_word[x]) begin
        hgt_nxt[x] = '0;
      end else if (hgt[x] == HGT_W'(MAX_ROWS)) begin
        hgt_nxt[x] = hgt[x];
      end else begin
        hgt_nxt[x] = hgt[x] + HGT_W'(1);
      end
      ok[x] = (SUM_W'(hgt_nxt[x]) >= SUM_W'(op.rows)) &&
              (SUM_W'(x) < SUM_W'(op.grid_cols));
    end
  end

  assign ok_ext = {{MAX_COLS{1'b0}}, ok};

  // a window of cols columns starting at x all tall enough
  always_comb begin
    for (int x = 0; x < MAX_COLS; x++) begin
      win = 1'b1;
      for (int j = 0; j < MAX_COLS; j++) begin
        if (SUM_W'(j) < SUM_W'(op.cols)) begin
          win = win & ok_ext[x+j];
        end
      end
      fit_vec[x] = win;
    end
  end

  always_comb begin
    fit.hit = |fit_vec;
    fit.col = '0;
    for (int x = MAX_COLS - 1; x >= 0; x--) begin
      if (fit_vec[x]) begin
        fit.col = COL_IW'(x);
      end
    end
  end

endmodule

[src/grid_rectangle_first_fit.sv]
// channel | direction | handshake                    | payload
// in_     | input     | in_tvalid / in_tready        | in_tdata: request item, 24 bits
// out_    | output    | out_tvalid / out_tready      | out_tdata: result item, 16 bits
// cfg_    | input     | psel, penable, pwrite, pready| grid_columns @0x0, grid_rows @0x4
//
// mark/clear: one occupancy row read-modified-written per cycle
// find: one candidate bottom row checked per cycle
// degenerate or out-of-bounds requests go from S_IDLE straight to S_DONE
// in_tready is low from acceptance until the result moves into the output register
// synchronous active-low reset clears the grid, sets both registers to 16
module grid_rectangle_first_fit
  import gfit_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // opcode[1:0], rect_col[5:2], rect_row[9:6], rect_cols[14:10], rect_rows[19:15]
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // status[1:0], found_col[5:2], found_row[9:6]
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RECT = 4'b0010,
    S_FIND = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] grid_columns_r, grid_rows_r;

  logic [ROW_IW-1:0]  cur_r, cur_nxt;
  logic [ROW_IW-1:0]  last_r, last_nxt;
  logic               set_r, set_nxt;
  logic [F_IDX_W-1:0] col_r, col_nxt;
  logic [F_CNT_W-1:0] cols_r, cols_nxt;
  logic [F_CNT_W-1:0] rows_r, rows_nxt;
  hgt_vec_t           hgt_r, hgt_nxt;
  status_t            res_st_r, res_st_nxt;
  logic [F_IDX_W-1:0] res_col_r, res_col_nxt;
  logic [F_IDX_W-1:0] res_row_r, res_row_nxt;

  logic               out_valid_r;
  status_t            out_st_r;
  logic [F_IDX_W-1:0] out_col_r, out_row_r;

  op_t                in_op;
  logic [F_IDX_W-1:0] in_col, in_row;
  logic [F_CNT_W-1:0] in_cols, in_rows;

  logic [COL_CW-1:0] gc;
  logic [ROW_CW-1:0] gr;

  row_word_t rd_word, wr_word;
  logic      wr_en;
  row_op_t   rop;
  hgt_vec_t  hgt_calc;
  fit_res_t  fit;
  logic      cfg_wr;
  logic [SUM_W-1:0] frow;

  assign in_op   = op_t'(in_tdata[1:0]);
  assign in_col  = in_tdata[5:2];
  assign in_row  = in_tdata[9:6];
  assign in_cols = in_tdata[14:10];
  assign in_rows = in_tdata[19:15];

  assign gc = (SUM_W'(grid_columns_r) > SUM_W'(MAX_COLS)) ? COL_CW'(MAX_COLS)
                                                          : COL_CW'(grid_columns_r);
  assign gr = (SUM_W'(grid_rows_r) > SUM_W'(MAX_ROWS)) ? ROW_CW'(MAX_ROWS)
                                                       : ROW_CW'(grid_rows_r);

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r <= CFG_W'(16);
      grid_rows_r    <= CFG_W'(16);
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_paddr[2]))
        REG_GRID_COLUMNS: grid_columns_r <= cfg_pwdata[CFG_W-1:0];
        REG_GRID_ROWS:    grid_rows_r    <= cfg_pwdata[CFG_W-1:0];
        default:          grid_rows_r    <= grid_rows_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[2]))
      REG_GRID_COLUMNS: cfg_prdata = APB_DW'(grid_columns_r);
      REG_GRID_ROWS:    cfg_prdata = APB_DW'(grid_rows_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // occupancy storage and the shared row unit
  gfit_occ_bank u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (cur_r),
    .rd_data (rd_word),
    .wr_en   (wr_en),
    .wr_idx  (cur_r),
    .wr_data (wr_word)
  );

  assign rop.set_bits  = set_r;
  assign rop.col       = col_r;
  assign rop.cols      = cols_r;
  assign rop.rows      = rows_r;
  assign rop.grid_cols = gc;

  gfit_row_unit u_row (
    .op       (rop),
    .row_word (rd_word),
    .hgt      (hgt_r),
    .row_new  (wr_word),
    .hgt_nxt  (hgt_calc),
    .fit      (fit)
  );

  assign wr_en     = (state_r == S_RECT);
  assign in_tready = (state_r == S_IDLE);

  // top row of the hit: bottom row minus height plus one
  assign frow = SUM_W'(cur_r) + SUM_W'(1) - SUM_W'(rows_r);

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    last_nxt    = last_r;
    set_nxt     = set_r;
    col_nxt     = col_r;
    cols_nxt    = cols_r;
    rows_nxt    = rows_r;
    hgt_nxt     = hgt_r;
    res_st_nxt  = res_st_r;
    res_col_nxt = res_col_r;
    res_row_nxt = res_row_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          set_nxt     = (in_op == OP_MARK);
          col_nxt     = in_col;
          cols_nxt    = in_cols;
          rows_nxt    = in_rows;
          res_st_nxt  = ST_OK;
          res_col_nxt = '0;
          res_row_nxt = '0;
          state_nxt   = S_DONE;
          unique case (in_op) inside
            OP_MARK, OP_CLEAR: begin
              if (in_cols != '0 && in_rows != '0) begin
                if (SUM_W'(in_col) + SUM_W'(in_cols) > SUM_W'(gc) ||
                    SUM_W'(in_row) + SUM_W'(in_rows) > SUM_W'(gr)) begin
                  res_st_nxt = ST_OOB;
                end else begin
                  cur_nxt   = ROW_IW'(in_row);
                  last_nxt  = ROW_IW'(SUM_W'(in_row) + SUM_W'(in_rows) - SUM_W'(1));
                  state_nxt = S_RECT;
                end
              end
            end
            OP_FIND: begin
              if (SUM_W'(in_cols) > SUM_W'(gc) || SUM_W'(in_rows) > SUM_W'(gr) ||
                  gc == '0 || gr == '0) begin
                res_st_nxt = ST_NOSPACE;
              end else if (in_cols != '0 && in_rows != '0) begin
                cur_nxt   = '0;
                hgt_nxt   = '0;
                state_nxt = S_FIND;
              end
            end
            default: begin
              res_st_nxt = ST_OK;
            end
          endcase
        end
      end
      S_RECT: begin
        if (cur_r == last_r) begin
          state_nxt = S_DONE;
        end else begin
          cur_nxt = cur_r + ROW_IW'(1);
        end
      end
      S_FIND: begin
        hgt_nxt = hgt_calc;
        if (fit.hit) begin
          res_st_nxt  = ST_OK;
          res_col_nxt = F_IDX_W'(fit.col);
          res_row_nxt = F_IDX_W'(frow);
          state_nxt   = S_DONE;
        end else if (ROW_CW'(cur_r) + ROW_CW'(1) == gr) begin
          res_st_nxt = ST_NOSPACE;
          state_nxt  = S_DONE;
        end else begin
          cur_nxt = cur_r + ROW_IW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    last_r    <= last_nxt;
    set_r     <= set_nxt;
    col_r     <= col_nxt;
    cols_r    <= cols_nxt;
    rows_r    <= rows_nxt;
    hgt_r     <= hgt_nxt;
    res_st_r  <= res_st_nxt;
    res_col_r <= res_col_nxt;
    res_row_r <= res_row_nxt;
  end

  // output register, loaded when the finished item can move in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_st_r  <= res_st_r;
      out_col_r <= res_col_r;
      out_row_r <= res_row_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - F_ST_W - 2 * F_IDX_W)'(0), out_row_r, out_col_r, out_st_r};

endmodule

[src/gfit_checker.sv]
`include "grid_rectangle_first_fit_defines.svh"

module gfit_checker
  import gfit_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  // one item in flight: the block is busy right after taking an item
  `GFIT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")

  `GFIT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // only a successful find carries a position
  `GFIT_ASSERT_NOW(a_pos_zero, out_tvalid && out_tdata[1:0] != ST_OK, out_tdata[9:2] == 8'd0, "position on non-hit")

  `GFIT_ASSERT_NOW(a_status_legal, out_tvalid, (out_tdata[1:0] == ST_OK || out_tdata[1:0] == ST_OOB || out_tdata[1:0] == ST_NOSPACE) && out_tdata[15:10] == 6'd0, "bad result code or padding")

endmodule

bind grid_rectangle_first_fit gfit_checker u_gfit_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import gfit_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;

  // request as it sits in in_tdata, opcode in the lowest bits
  typedef struct packed {
    logic [F_CNT_W-1:0] rect_rows;
    logic [F_CNT_W-1:0] rect_cols;
    logic [F_IDX_W-1:0] rect_row;
    logic [F_IDX_W-1:0] rect_col;
    op_t                opcode;
  } grid_req_t;

  // result as it sits in out_tdata, status in the lowest bits
  typedef struct packed {
    logic [F_IDX_W-1:0] found_row;
    logic [F_IDX_W-1:0] found_col;
    status_t            status;
  } grid_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  grid_rectangle_first_fit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // shadow of the grid and its registers
  logic [MAX_COLS-1:0] cell_map [MAX_ROWS];
  logic [CFG_W-1:0]    grid_cols_reg = 5'd16;
  logic [CFG_W-1:0]    grid_rows_reg = 5'd16;

  grid_req_t    req_q[$];
  grid_result_t expect_q[$];
  grid_req_t    cur_req;

  int items_queued = 0;
  int results_seen = 0;
  int errors = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit calm = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int n_mark = 0, n_clear = 0, n_find = 0, n_other = 0;
  int n_hit = 0, n_oob = 0, n_nospace = 0, n_settings = 0;

  function automatic int used_cols();
    return (grid_cols_reg > MAX_COLS) ? MAX_COLS : int'(grid_cols_reg);
  endfunction

  function automatic int used_rows();
    return (grid_rows_reg > MAX_ROWS) ? MAX_ROWS : int'(grid_rows_reg);
  endfunction

  // applies one request to the shadow grid and returns its result
  function automatic grid_result_t apply_request(grid_req_t r);
    grid_result_t res;
    int           uc, ur, c, rw, w, h, x, y, k;
    logic [31:0]  mask;
    bit           hit, fits;
    res = '0;
    res.status = ST_OK;
    uc = used_cols();
    ur = used_rows();
    c = r.rect_col;
    rw = r.rect_row;
    w = r.rect_cols;
    h = r.rect_rows;
    case (r.opcode)
      OP_MARK, OP_CLEAR: begin
        if (w != 0 && h != 0) begin
          if (c + w > uc || rw + h > ur) begin
            res.status = ST_OOB;
          end else begin
            mask = ((32'd1 << w) - 32'd1) << c;
            for (y = rw; y < rw + h; y++) begin
              if (r.opcode == OP_MARK) cell_map[y] = cell_map[y] | mask[MAX_COLS-1:0];
              else cell_map[y] = cell_map[y] & ~mask[MAX_COLS-1:0];
            end
          end
        end
      end
      OP_FIND: begin
        res.status = ST_NOSPACE;
        hit = 1'b0;
        for (y = 0; y < ur && y + h <= ur && !hit; y++) begin
          for (x = 0; x < uc && x + w <= uc && !hit; x++) begin
            mask = ((32'd1 << w) - 32'd1) << x;
            fits = 1'b1;
            for (k = y; k < y + h; k++) begin
              if ((cell_map[k] & mask[MAX_COLS-1:0]) != '0) fits = 1'b0;
            end
            if (fits) begin
              hit = 1'b1;
              res.status = ST_OK;
              res.found_col = 4'(x);
              res.found_row = 4'(y);
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // driver: presents queued requests, predicts each one as it is taken
  always @(posedge clk) begin
    grid_result_t pred;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pred = apply_request(cur_req);
        expect_q.push_back(pred);
        case (cur_req.opcode)
          OP_MARK:  n_mark++;
          OP_CLEAR: n_clear++;
          OP_FIND:  n_find++;
          default:  n_other++;
        endcase
        if (pred.status == ST_OOB) n_oob++;
        if (pred.status == ST_NOSPACE) n_nospace++;
        if (cur_req.opcode == OP_FIND && pred.status == ST_OK) n_hit++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_W - $bits(grid_req_t)){1'b0}}, cur_req};
          if (!calm && $urandom_range(0, 99) < tx_idle_pct) tx_gap <= $urandom_range(1, 9);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result item against the oldest prediction
  always @(posedge clk) begin
    grid_result_t got, want;
    bit           rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = grid_result_t'(out_tdata[$bits(grid_result_t)-1:0]);
        if (expect_q.size() == 0) begin
          $display("%0t: unexpected result item, got status %0d col %0d row %0d",
                   $time, got.status, got.found_col, got.found_row);
          errors++;
        end else begin
          want = expect_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            errors++;
          end
          if (got.found_col !== want.found_col) begin
            $display("%0t: found_col mismatch, expected %0d, got %0d",
                     $time, want.found_col, got.found_col);
            errors++;
          end
          if (got.found_row !== want.found_row) begin
            $display("%0t: found_row mismatch, expected %0d, got %0d",
                     $time, want.found_row, got.found_row);
            errors++;
          end
        end
        results_seen++;
      end
      if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        rdy = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (!calm && $urandom_range(0, 99) < rx_idle_pct) rx_gap = $urandom_range(1, 9);
      end
      out_tready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d results seen", $time, results_seen, items_queued);
      $display("testbench failed");
      $finish;
    end
  end

  task automatic push_req(op_t op, int col, int row, int cols, int rows);
    grid_req_t r;
    r.opcode = op;
    r.rect_col = 4'(col);
    r.rect_row = 4'(row);
    r.rect_cols = 5'(cols);
    r.rect_rows = 5'(rows);
    req_q.push_back(r);
    items_queued++;
  endtask

  function automatic int pick_span(int limit);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(1, (limit < 4) ? limit : 4);
    if (r < 8) return $urandom_range(1, limit);
    if (r == 8) return limit;
    return 0;
  endfunction

  task automatic push_random();
    int uc, ur, w, h, p;
    op_t op;
    uc = used_cols();
    ur = used_rows();
    p = $urandom_range(0, 99);
    if (uc == 0 || ur == 0) p = 85 + $urandom_range(0, 14);
    if (p < 3) begin
      push_req(OP_CLEAR, 0, 0, uc, ur);
    end else if (p < 55) begin
      // in-bounds rectangle
      op = (p < 33) ? OP_MARK : OP_CLEAR;
      w = pick_span(uc);
      h = pick_span(ur);
      push_req(op, (w == 0) ? $urandom_range(0, 15) : $urandom_range(0, uc - w),
               (h == 0) ? $urandom_range(0, 15) : $urandom_range(0, ur - h), w, h);
    end else if (p < 85) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : pick_span(uc);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : pick_span(ur);
      push_req(OP_FIND, $urandom_range(0, 15), $urandom_range(0, 15), w, h);
    end else begin
      if (p < 93) op = $urandom_range(0, 1) ? OP_MARK : OP_CLEAR;
      else if (p < 97) op = OP_FIND;
      else op = OP_NOP;
      push_req(op, $urandom_range(0, 15), $urandom_range(0, 15),
               $urandom_range(0, 16), $urandom_range(0, 16));
    end
  endtask

  task automatic wait_drained();
    while (results_seen != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write followed by a read back
  task automatic cfg_write(reg_idx_t idx, logic [CFG_W-1:0] value);
    logic [APB_DW-1:0] rd;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {8'($urandom_range(0, 255)), 19'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_GRID_COLUMNS) grid_cols_reg = value;
    else grid_rows_reg = value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[CFG_W-1:0] !== value) begin
      $display("%0t: register %0d read back mismatch, expected %0d, got %0d",
               $time, idx, value, rd[CFG_W-1:0]);
      errors++;
    end
  endtask

  task automatic run_phase(int cols, int rows, int count, int tx_pct, int rx_pct);
    int i;
    wait_drained();
    cfg_write(REG_GRID_COLUMNS, 5'(cols));
    cfg_write(REG_GRID_ROWS, 5'(rows));
    n_settings++;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (i = 0; i < count; i++) push_random();
  endtask

  initial begin
    int i;
    for (i = 0; i < MAX_ROWS; i++) cell_map[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests on the full default grid
    n_settings = 1;
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    push_req(OP_FIND, 0, 0, 1, 1);
    push_req(OP_FIND, 15, 15, 0, 0);
    push_req(OP_FIND, 0, 0, 16, 16);
    push_req(OP_FIND, 0, 0, 16, 0);
    push_req(OP_MARK, 0, 0, 1, 1);
    push_req(OP_FIND, 0, 0, 1, 1);
    push_req(OP_MARK, 15, 15, 1, 1);
    push_req(OP_MARK, 15, 0, 2, 1);
    push_req(OP_MARK, 0, 15, 1, 2);
    push_req(OP_MARK, 15, 15, 0, 16);
    push_req(OP_CLEAR, 3, 3, 16, 0);
    push_req(OP_FIND, 0, 0, 16, 16);
    push_req(OP_CLEAR, 0, 0, 16, 16);
    push_req(OP_MARK, 0, 0, 16, 1);
    push_req(OP_FIND, 9, 9, 2, 2);
    push_req(OP_MARK, 4, 4, 8, 8);
    push_req(OP_FIND, 0, 0, 16, 4);
    push_req(OP_FIND, 0, 0, 4, 12);
    push_req(OP_NOP, 15, 15, 16, 16);
    push_req(OP_CLEAR, 15, 15, 1, 1);
    push_req(OP_MARK, 0, 0, 16, 16);
    push_req(OP_FIND, 0, 0, 1, 1);
    push_req(OP_CLEAR, 0, 0, 16, 16);
    wait_drained();

    // receiver holds off while the sender keeps offering
    tx_idle_pct = 0;
    hold_requests++;
    for (i = 0; i < 250; i++) push_random();

    run_phase(1, 1, 60, 30, 30);
    run_phase(0, 9, 40, 20, 20);
    run_phase(9, 0, 40, 20, 20);
    run_phase(31, 31, 150, 0, 0);
    run_phase(17, 5, 80, 40, 10);
    run_phase(5, 3, 80, 10, 40);
    run_phase($urandom_range(1, 16), $urandom_range(1, 16), 100, 30, 30);
    run_phase($urandom_range(1, 16), $urandom_range(1, 16), 100, 30, 30);

    // second hold-off, then a sender pause until all results are back
    run_phase(16, 16, 100, 25, 25);
    hold_requests++;
    wait_drained();
    for (i = 0; i < 100; i++) push_random();

    // last stretch without idling on either side
    wait_drained();
    calm = 1'b1;
    for (i = 0; i < 150; i++) push_random();

    wait_drained();
    repeat (20) @(posedge clk);
    if (expect_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expect_q.size());
      errors++;
    end
    $display("covered %0d requests (mark %0d, clear %0d, find %0d, unused op %0d)",
             items_queued, n_mark, n_clear, n_find, n_other);
    $display("over %0d grid settings: %0d finds hit, %0d no space, %0d out of bounds",
             n_settings, n_hit, n_nospace, n_oob);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/gfit_pkg.sv
src/gfit_occ_bank.sv
src/gfit_row_unit.sv
src/grid_rectangle_first_fit.sv
src/gfit_checker.sv
dv/testbench.sv
